// File: hdl/tbc_pkg.sv
// Package for the tiny byte CPU: sizes, request and opcode codes, and the
// structs passed between the sequencer, the shared ALU and the byte memory.
// No dependencies.
package tbc_pkg;

	// Both depths must be powers of two: indices are taken from the low bits.
	localparam int NUM_REGS  = 8;
	localparam int MEM_DEPTH = 256;
	localparam int REG_IW    = $clog2(NUM_REGS);
	localparam int MEM_AW    = $clog2(MEM_DEPTH);

	localparam logic [7:0] ADD_LIMIT_RESET = 8'd128;

	// Request codes on op.
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_START = 2'd1;
	localparam logic [1:0] REQ_WRITE = 2'd2;
	localparam logic [1:0] REQ_READ  = 2'd3;

	// Instruction opcode bytes.
	localparam logic [7:0] OPC_LOADL    = 8'd0;
	localparam logic [7:0] OPC_LOADA    = 8'd1;
	localparam logic [7:0] OPC_ADD      = 8'd2;
	localparam logic [7:0] OPC_SUBTRACT = 8'd3;
	localparam logic [7:0] OPC_STORE    = 8'd4;
	localparam logic [7:0] OPC_JUMP     = 8'd5;
	localparam logic [7:0] OPC_STOP     = 8'd6;

	typedef logic [1:0] alu_op_t;
	localparam alu_op_t ALU_ADD = 2'd0;  // wrapping add, used for the PC
	localparam alu_op_t ALU_SAT = 2'd1;  // add saturating at the limit
	localparam alu_op_t ALU_SUB = 2'd2;  // subtract clamping at zero

	typedef struct packed {
		alu_op_t    op;
		logic [7:0] x;
		logic [7:0] y;
	} alu_req_t;

	typedef struct packed {
		logic [7:0] value;
		logic       flag;
	} alu_rsp_t;

	typedef struct packed {
		logic              we;
		logic              re;
		logic [MEM_AW-1:0] addr;
		logic [7:0]        wdata;
	} mem_req_t;

endpackage

// File: hdl/tiny_byte_cpu_step.sv
// Top level of the tiny byte CPU: request sequencer, register file, state
// flags and result registers. Depends on tbc_pkg, tbc_alu and tbc_mem.
//
//  channel   | handshake            | signals
//  ----------+----------------------+---------------------------------------------
//  request   | start, busy          | op, address, write_data
//  result    | done (one-cycle)     | running, program_counter, overflow_flag,
//            |                      | underflow_flag, bad_opcode, executed_opcode,
//            |                      | read_data
//  config    | add_limit_we         | add_limit_wdata
//
// Handshake: a request is taken when start is high and busy is low; done pulses
// on the edge that completes it. Start, memory write, memory read and a tick
// while stopped complete straight from idle. A running tick takes one state per
// byte read through the single memory port, plus ST_REGB for the second register
// read of ADD and SUBTRACT: JUMP uses ST_OPC and ST_JMP, STOP and an unknown
// opcode ST_OPC only, LOADL and STORE run up to ST_OPB, LOADA on to ST_DATA.
// Reset clears the sequencer, flags, register file and memory valid bits at
// once; there is no clearing pass. The receiver cannot stall, and a new
// request may be taken in the same cycle that done is shown.
module tiny_byte_cpu_step import tbc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] op,
	input  logic [7:0] address,
	input  logic [7:0] write_data,
	input  logic       add_limit_we,
	input  logic [7:0] add_limit_wdata,
	output logic       done,
	output logic       running,
	output logic [7:0] program_counter,
	output logic       overflow_flag,
	output logic       underflow_flag,
	output logic       bad_opcode,
	output logic [7:0] executed_opcode,
	output logic [7:0] read_data
);

	// Sequencer states: idle, the second register read, and one per memory byte that an instruction reads.
	localparam logic [2:0] ST_IDLE = 3'd0;  // wait for a request
	localparam logic [2:0] ST_OPC  = 3'd1;  // opcode byte arrives
	localparam logic [2:0] ST_OPA  = 3'd2;  // first operand arrives
	localparam logic [2:0] ST_OPB  = 3'd3;  // second operand arrives
	localparam logic [2:0] ST_REGB = 3'd4;  // second register read, ALU op
	localparam logic [2:0] ST_DATA = 3'd5;  // LOADA data byte arrives
	localparam logic [2:0] ST_JMP  = 3'd6;  // jump offset arrives

	logic [2:0]        state_q;
	logic [7:0]        pc_q;
	logic              run_q;
	logic              ovf_q;
	logic              unf_q;
	logic              done_q;
	logic              bad_q;
	logic              rd_q;
	logic [7:0]        exec_q;
	logic [7:0]        add_limit_q;
	logic [7:0]        rf_q [NUM_REGS];
	logic [REG_IW-1:0] a_q;
	logic [REG_IW-1:0] b_q;
	logic [7:0]        x_q;

	logic              accept;
	logic [REG_IW-1:0] rf_raddr;
	logic [7:0]        rf_rdata;
	logic [7:0]        mem_rdata;
	mem_req_t          mem_req;
	alu_req_t          alu_req;
	alu_rsp_t          alu_rsp;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign rf_raddr = (state_q == ST_REGB) ? b_q : a_q;
	assign rf_rdata = rf_q[rf_raddr];

	tbc_mem u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	tbc_alu u_alu (
		.req      (alu_req),
		.add_limit(add_limit_q),
		.rsp      (alu_rsp)
	);

	// Memory port and ALU steering. By default the ALU advances the PC by one,
	// which is what every operand fetch needs.
	always_comb begin
		mem_req = '0;
		alu_req = '{op: ALU_ADD, x: pc_q, y: 8'd1};
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (op)
						REQ_READ: begin
							mem_req.re   = 1'b1;
							mem_req.addr = address[MEM_AW-1:0];
						end
						REQ_WRITE: begin
							mem_req.we    = 1'b1;
							mem_req.addr  = address[MEM_AW-1:0];
							mem_req.wdata = write_data;
						end
						REQ_TICK: begin
							mem_req.re   = run_q;
							mem_req.addr = pc_q[MEM_AW-1:0];
						end
						default: begin
							mem_req = '0;
						end
					endcase
				end
			end
			ST_OPC: begin
				// Fetch the first operand, or the jump offset.
				mem_req.re   = (mem_rdata <= OPC_JUMP);
				mem_req.addr = pc_q[MEM_AW-1:0];
			end
			ST_OPA: begin
				mem_req.re   = 1'b1;
				mem_req.addr = pc_q[MEM_AW-1:0];
			end
			ST_OPB: begin
				if (exec_q == OPC_LOADA) begin
					mem_req.re   = 1'b1;
					mem_req.addr = mem_rdata[MEM_AW-1:0];
				end else if (exec_q == OPC_STORE) begin
					mem_req.we    = 1'b1;
					mem_req.addr  = mem_rdata[MEM_AW-1:0];
					mem_req.wdata = rf_rdata;
				end
			end
			ST_REGB: begin
				alu_req.op = (exec_q == OPC_ADD) ? ALU_SAT : ALU_SUB;
				alu_req.x  = x_q;
				alu_req.y  = rf_rdata;
			end
			ST_JMP: begin
				alu_req.y = mem_rdata;
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	// Sequencer, CPU state and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pc_q        <= 8'd0;
			run_q       <= 1'b0;
			ovf_q       <= 1'b0;
			unf_q       <= 1'b0;
			done_q      <= 1'b0;
			bad_q       <= 1'b0;
			rd_q        <= 1'b0;
			exec_q      <= 8'd0;
			add_limit_q <= ADD_LIMIT_RESET;
			for (int i = 0; i < NUM_REGS; i++) begin
				rf_q[i] <= 8'd0;
			end
		end else begin
			done_q <= 1'b0;
			if (add_limit_we) begin
				add_limit_q <= add_limit_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						// Drop the previous request's per-request fields.
						bad_q  <= 1'b0;
						exec_q <= 8'd0;
						rd_q   <= (op == REQ_READ);
						if (op == REQ_START) begin
							pc_q  <= address;
							run_q <= 1'b1;
						end
						if (op == REQ_TICK && run_q) begin
							pc_q    <= alu_rsp.value;
							state_q <= ST_OPC;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				ST_OPC: begin
					exec_q <= mem_rdata;
					unique case (mem_rdata) inside
						OPC_LOADL, OPC_LOADA, OPC_ADD, OPC_SUBTRACT, OPC_STORE: begin
							pc_q    <= alu_rsp.value;
							state_q <= ST_OPA;
						end
						OPC_JUMP: begin
							// PC stays on the offset byte.
							state_q <= ST_JMP;
						end
						OPC_STOP: begin
							run_q   <= 1'b0;
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
						default: begin
							// Unknown opcode: only the opcode byte is consumed.
							bad_q   <= 1'b1;
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_OPA: begin
					pc_q    <= alu_rsp.value;
					state_q <= ST_OPB;
				end
				ST_OPB: begin
					unique case (exec_q) inside
						OPC_LOADL: begin
							rf_q[a_q] <= mem_rdata;
							done_q    <= 1'b1;
							state_q   <= ST_IDLE;
						end
						OPC_LOADA: begin
							state_q <= ST_DATA;
						end
						OPC_ADD, OPC_SUBTRACT: begin
							state_q <= ST_REGB;
						end
						default: begin
							// STORE: the write went out this cycle.
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_REGB: begin
					rf_q[a_q] <= alu_rsp.value;
					if (exec_q == OPC_ADD) begin
						ovf_q <= alu_rsp.flag;
					end else begin
						unf_q <= alu_rsp.flag;
					end
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_DATA: begin
					rf_q[a_q] <= mem_rdata;
					done_q    <= 1'b1;
					state_q   <= ST_IDLE;
				end
				ST_JMP: begin
					pc_q    <= alu_rsp.value;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Operand registers: no reset needed.
	always_ff @(posedge clk) begin
		if (state_q == ST_OPA) begin
			a_q <= mem_rdata[REG_IW-1:0];
		end
		if (state_q == ST_OPB) begin
			b_q <= mem_rdata[REG_IW-1:0];
			x_q <= rf_rdata;
		end
	end

	assign done            = done_q;
	assign running         = run_q;
	assign program_counter = pc_q;
	assign overflow_flag   = ovf_q;
	assign underflow_flag  = unf_q;
	assign bad_opcode      = bad_q;
	assign executed_opcode = exec_q;
	assign read_data       = rd_q ? mem_rdata : 8'd0;

	// A result is only shown once the sequencer is back at rest.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while sequencer busy");

	// Every request taken either completes at once or keeps the block busy.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("request taken but neither busy nor done");

	// An unknown opcode flag comes only with an opcode byte above STOP.
	a_bad_code: assert property (@(posedge clk) disable iff (!arst_n)
		(done && bad_opcode) |-> (executed_opcode > OPC_STOP))
		else $error("bad_opcode with a known opcode");

	// Arithmetic flags move only on the edge that completes a request.
	a_flags_move: assert property (@(posedge clk) disable iff (!arst_n)
		(!$stable(overflow_flag) || !$stable(underflow_flag)) |-> done)
		else $error("flag changed outside a completion");

endmodule

// File: hdl/tbc_alu.sv
// Shared arithmetic unit of the tiny byte CPU: PC add, saturating add and
// clamped subtract. Depends on tbc_pkg.
module tbc_alu import tbc_pkg::*; (
	input  alu_req_t   req,
	input  logic [7:0] add_limit,
	output alu_rsp_t   rsp
);

	logic [8:0] sum;

	assign sum = {1'b0, req.x} + {1'b0, req.y};

	always_comb begin
		rsp = '0;
		unique case (req.op)
			ALU_ADD: begin
				rsp.value = sum[7:0];
			end
			ALU_SAT: begin
				if (sum > {1'b0, add_limit}) begin
					rsp.value = add_limit;
					rsp.flag  = 1'b1;
				end else begin
					rsp.value = sum[7:0];
				end
			end
			ALU_SUB: begin
				if (req.x < req.y) begin
					rsp.flag = 1'b1;
				end else begin
					rsp.value = req.x - req.y;
				end
			end
			default: begin
				rsp = '0;
			end
		endcase
	end

endmodule

// File: hdl/tbc_mem.sv
// Single-port byte memory of the tiny byte CPU with registered read data and
// one valid bit per entry, so unwritten bytes read as zero after reset.
// Depends on tbc_pkg.
module tbc_mem import tbc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  mem_req_t   req,
	output logic [7:0] rdata
);

	logic [7:0]           mem_q [MEM_DEPTH];
	logic [MEM_DEPTH-1:0] valid_q;
	logic [7:0]           raw_q;
	logic                 hit_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.addr] <= req.wdata;
		end
		if (req.re) begin
			raw_q <= mem_q[req.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_q   <= 1'b0;
		end else begin
			if (req.we) begin
				valid_q[req.addr] <= 1'b1;
			end
			if (req.re) begin
				hit_q <= valid_q[req.addr];
			end
		end
	end

	assign rdata = hit_q ? raw_q : 8'd0;

endmodule
